/* rtl/lpst_pkg.sv */
// Shared types and constants of the page slot replacement table.
`timescale 1ns / 1ps

package lpst_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam logic [6:0] TOTAL_PAGES_RST = 7'd64;
    localparam logic [3:0] OFFSET_LAST = 4'd10;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_ACCESS = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [15:0] page;
        logic [3:0]  offset;
        logic [15:0] count;
    } entry_t;

endpackage

/* rtl/lpst_ram.sv */
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps

module lpst_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/lfu_page_slot_table.sv */
// Top level of the least-frequently-used page slot table.
// An add without eviction passes S_APPEND, an access S_ACC_RD and S_ACC_WR; lookup scans up
// to N slots, remove scans and on a match compacts, an evicting add scans all N, compacts and
// appends, where N is the number of occupied slots (one memory read per cycle).
// One word is worked on at a time; the next is taken once the result has been registered.
// Reset clears the control state; the table memory is not cleared and needs no pass.
`timescale 1ns / 1ps

module lfu_page_slot_table
    import lpst_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] page_no,
    input  logic [3:0]  offset,
    input  logic [3:0]  initial_count,
    input  logic [5:0]  slot_index,
    input  logic [3:0]  increment,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [5:0]  found_slot,
    output logic [15:0] assigned_page,
    output logic [3:0]  assigned_offset,
    output logic        evicted,
    output logic [15:0] evicted_page,
    output logic [3:0]  evicted_offset,
    output logic [6:0]  free_pages,
    output logic [6:0]  occupancy
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_ACC_RD = 3'd4;
    localparam logic [2:0] S_ACC_WR = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [6:0]       free_reg, free_next;
    logic [15:0]      pcur_reg, pcur_next;
    logic [3:0]       ocur_reg, ocur_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             pend_reg, pend_next;

    // Working registers
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] gap_reg, gap_next;
    logic [15:0]      min_cnt_reg, min_cnt_next;
    logic [1:0]       op_reg, op_next;
    logic [15:0]      key_page_reg, key_page_next;
    logic [3:0]       key_off_reg, key_off_next;
    logic [3:0]       init_reg, init_next;
    logic [5:0]       sidx_reg, sidx_next;
    logic [3:0]       inc_reg, inc_next;

    // Result staging
    logic [1:0]  res_status_reg, res_status_next;
    logic [5:0]  res_slot_reg, res_slot_next;
    logic [15:0] res_apage_reg, res_apage_next;
    logic [3:0]  res_aoff_reg, res_aoff_next;
    logic        res_ev_reg, res_ev_next;
    logic [15:0] res_epage_reg, res_epage_next;
    logic [3:0]  res_eoff_reg, res_eoff_next;

    // Output word
    logic [1:0]  status_reg, status_next;
    logic [5:0]  found_slot_reg, found_slot_next;
    logic [15:0] assigned_page_reg, assigned_page_next;
    logic [3:0]  assigned_offset_reg, assigned_offset_next;
    logic        evicted_reg, evicted_next;
    logic [15:0] evicted_page_reg, evicted_page_next;
    logic [3:0]  evicted_offset_reg, evicted_offset_next;
    logic [6:0]  free_pages_reg, free_pages_next;
    logic [6:0]  occupancy_reg, occupancy_next;

    // Memory port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    logic        req_accept;
    logic        issue;
    logic        need_evict;
    logic        key_match;
    logic        cur_wrap;
    logic [15:0] new_page;
    logic [3:0]  new_off;
    logic [16:0] cnt_sum;

    lpst_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign issue      = (idx_reg < used_reg);
    assign need_evict = (free_reg == 7'd0) || (used_reg == CNT_W'(TABLE_DEPTH));
    assign key_match  = (ram_rdata.page == key_page_reg) && (ram_rdata.offset == key_off_reg);
    assign cur_wrap   = (ocur_reg > OFFSET_LAST);
    assign new_page   = cur_wrap ? (pcur_reg + 16'd1) : pcur_reg;
    assign new_off    = cur_wrap ? 4'd0 : ocur_reg;
    assign cnt_sum    = {1'b0, ram_rdata.count} + {13'd0, inc_reg};

    always_comb
    begin
        state_next           = state_reg;
        used_next            = used_reg;
        free_next            = free_reg;
        pcur_next            = pcur_reg;
        ocur_next            = ocur_reg;
        rsp_valid_next       = rsp_valid_reg;
        pend_next            = pend_reg;
        idx_next             = idx_reg;
        pend_idx_next        = pend_idx_reg;
        wr_ptr_next          = wr_ptr_reg;
        gap_next             = gap_reg;
        min_cnt_next         = min_cnt_reg;
        op_next              = op_reg;
        key_page_next        = key_page_reg;
        key_off_next         = key_off_reg;
        init_next            = init_reg;
        sidx_next            = sidx_reg;
        inc_next             = inc_reg;
        res_status_next      = res_status_reg;
        res_slot_next        = res_slot_reg;
        res_apage_next       = res_apage_reg;
        res_aoff_next        = res_aoff_reg;
        res_ev_next          = res_ev_reg;
        res_epage_next       = res_epage_reg;
        res_eoff_next        = res_eoff_reg;
        status_next          = status_reg;
        found_slot_next      = found_slot_reg;
        assigned_page_next   = assigned_page_reg;
        assigned_offset_next = assigned_offset_reg;
        evicted_next         = evicted_reg;
        evicted_page_next    = evicted_page_reg;
        evicted_offset_next  = evicted_offset_reg;
        free_pages_next      = free_pages_reg;
        occupancy_next       = occupancy_reg;
        ram_we               = 1'b0;
        ram_waddr            = wr_ptr_reg;
        ram_wdata            = ram_rdata;
        ram_re               = 1'b0;
        ram_raddr            = idx_reg[IDX_W-1:0];

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    op_next         = operation;
                    key_page_next   = page_no;
                    key_off_next    = offset;
                    init_next       = initial_count;
                    sidx_next       = slot_index;
                    inc_next        = increment;
                    res_status_next = ST_DONE;
                    res_slot_next   = 6'd0;
                    res_apage_next  = 16'd0;
                    res_aoff_next   = 4'd0;
                    res_ev_next     = 1'b0;
                    res_epage_next  = 16'd0;
                    res_eoff_next   = 4'd0;
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    case (operation)
                        OP_ADD:
                        begin
                            if (need_evict && (used_reg == '0))
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else if (need_evict)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_APPEND;
                            end
                        end
                        OP_ACCESS:
                        begin
                            if (32'(slot_index) < 32'(used_reg))
                            begin
                                state_next = S_ACC_RD;
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_DONE;
                            end
                        end
                        default:
                        begin
                            if (used_reg == '0)
                            begin
                                res_status_next = ST_NOT_FOUND;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Reads are issued one per cycle; each is judged in the next cycle, once its data is registered.
                ram_re        = issue;
                pend_next     = issue;
                pend_idx_next = idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (op_reg == OP_ADD)
                begin
                    if (pend_reg && ((pend_idx_reg == '0) || (ram_rdata.count < min_cnt_reg)))
                    begin
                        min_cnt_next   = ram_rdata.count;
                        gap_next       = pend_idx_reg;
                        res_epage_next = ram_rdata.page;
                        res_eoff_next  = ram_rdata.offset;
                    end
                    if (!issue && !pend_reg)
                    begin
                        res_ev_next = 1'b1;
                        wr_ptr_next = gap_reg;
                        idx_next    = CNT_W'(gap_reg) + 1'b1;
                        pend_next   = 1'b0;
                        state_next  = S_SHIFT;
                    end
                end
                else
                begin
                    if (pend_reg && key_match)
                    begin
                        res_slot_next = 6'(pend_idx_reg);
                        if (op_reg == OP_REMOVE)
                        begin
                            wr_ptr_next = pend_idx_reg;
                            idx_next    = CNT_W'(pend_idx_reg) + 1'b1;
                            pend_next   = 1'b0;
                            state_next  = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else if (!issue && !pend_reg)
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_slot_next   = 6'd0;
                        state_next      = S_DONE;
                    end
                end
            end

            S_SHIFT:
            begin
                // Each later slot moves down by one: read above, write below.
                ram_re    = issue;
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = wr_ptr_reg;
                    ram_wdata   = ram_rdata;
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    used_next = used_reg - 1'b1;
                    if (free_reg != 7'h7F)
                    begin
                        free_next = free_reg + 7'd1;
                    end
                    state_next = (op_reg == OP_ADD) ? S_APPEND : S_DONE;
                end
            end

            S_APPEND:
            begin
                ram_we           = 1'b1;
                ram_waddr        = used_reg[IDX_W-1:0];
                ram_wdata.page   = new_page;
                ram_wdata.offset = new_off;
                ram_wdata.count  = {12'd0, init_reg};
                res_slot_next    = 6'(used_reg);
                res_apage_next   = new_page;
                res_aoff_next    = new_off;
                pcur_next        = new_page;
                ocur_next        = new_off + 4'd1;
                used_next        = used_reg + 1'b1;
                if (free_reg != 7'd0)
                begin
                    free_next = free_reg - 7'd1;
                end
                state_next = S_DONE;
            end

            S_ACC_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = IDX_W'(sidx_reg);
                state_next = S_ACC_WR;
            end

            S_ACC_WR:
            begin
                ram_we           = 1'b1;
                ram_waddr        = IDX_W'(sidx_reg);
                ram_wdata.page   = ram_rdata.page;
                ram_wdata.offset = ram_rdata.offset;
                ram_wdata.count  = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
                res_slot_next    = sidx_reg;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    status_next          = res_status_reg;
                    found_slot_next      = res_slot_reg;
                    assigned_page_next   = res_apage_reg;
                    assigned_offset_next = res_aoff_reg;
                    evicted_next         = res_ev_reg;
                    evicted_page_next    = res_epage_reg;
                    evicted_offset_next  = res_eoff_reg;
                    free_pages_next      = free_reg;
                    occupancy_next       = 7'(used_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The user must rewrite the page count only while no word is in progress; the block does not enforce it.
        if (cfg_wr_en)
        begin
            free_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            free_reg      <= TOTAL_PAGES_RST;
            pcur_reg      <= 16'd0;
            ocur_reg      <= 4'd0;
            rsp_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            free_reg      <= free_next;
            pcur_reg      <= pcur_next;
            ocur_reg      <= ocur_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg             <= idx_next;
        pend_idx_reg        <= pend_idx_next;
        wr_ptr_reg          <= wr_ptr_next;
        gap_reg             <= gap_next;
        min_cnt_reg         <= min_cnt_next;
        op_reg              <= op_next;
        key_page_reg        <= key_page_next;
        key_off_reg         <= key_off_next;
        init_reg            <= init_next;
        sidx_reg            <= sidx_next;
        inc_reg             <= inc_next;
        res_status_reg      <= res_status_next;
        res_slot_reg        <= res_slot_next;
        res_apage_reg       <= res_apage_next;
        res_aoff_reg        <= res_aoff_next;
        res_ev_reg          <= res_ev_next;
        res_epage_reg       <= res_epage_next;
        res_eoff_reg        <= res_eoff_next;
        status_reg          <= status_next;
        found_slot_reg      <= found_slot_next;
        assigned_page_reg   <= assigned_page_next;
        assigned_offset_reg <= assigned_offset_next;
        evicted_reg         <= evicted_next;
        evicted_page_reg    <= evicted_page_next;
        evicted_offset_reg  <= evicted_offset_next;
        free_pages_reg      <= free_pages_next;
        occupancy_reg       <= occupancy_next;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign found_slot      = found_slot_reg;
    assign assigned_page   = assigned_page_reg;
    assign assigned_offset = assigned_offset_reg;
    assign evicted         = evicted_reg;
    assign evicted_page    = evicted_page_reg;
    assign evicted_offset  = evicted_offset_reg;
    assign free_pages      = free_pages_reg;
    assign occupancy       = occupancy_reg;

`ifndef SYNTHESIS
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("occupancy exceeds the table depth");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |->
            ((used_reg == $past(used_reg) + 1'b1) || (used_reg == $past(used_reg) - 1'b1)))
        else $error("occupancy moved by more than one slot");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !ram_we)
        else $error("table written while no word is in progress");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == S_SHIFT) |-> (CNT_W'(wr_ptr_reg) < used_reg))
        else $error("compaction wrote beyond the occupied slots");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result word raised outside the completion state");
`endif

endmodule
